// ===== src/slbs_pkg.sv =====
`timescale 1ns / 1ps
package slbs_pkg;

    localparam int OFFSET_BITS        = 24;
    localparam int LINE_BITS          = 16;
    localparam int MAX_TEMPLATE_DEPTH = 15;
    localparam int DEPTH_BITS         = 4;
    localparam int BRACE_BITS         = 16;
    localparam int SYM_COUNT          = 48;
    localparam int SYM_BITS           = 6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BTICK = 8'h60;

    localparam logic [SYM_BITS-1:0] SYM_SLASH = 6'd27;
    localparam logic [SYM_BITS-1:0] SYM_DOT   = 6'd43;

    typedef enum logic [3:0] {
        K_EOL    = 4'd0,
        K_SYM    = 4'd1,
        K_NUM    = 4'd2,
        K_COM    = 4'd3,
        K_WORD   = 4'd4,
        K_RX     = 4'd5,
        K_STR    = 4'd6,
        K_TPL    = 4'd7,
        K_TSTART = 4'd8,
        K_TPART  = 4'd9,
        K_TEND   = 4'd10,
        K_ERR    = 4'd11
    } t_kind;

    typedef enum logic [4:0] {
        M_IDLE, M_WORD, M_ZERO, M_INT, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT,
        M_BIN, M_LCOM, M_BCOM, M_SLASH, M_DOT, M_SYM, M_RXB, M_RXF, M_STR, M_TPL
    } t_mode;

    typedef struct packed {
        t_kind                  kind;
        logic [SYM_BITS-1:0]    sym;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
    } t_token;

    // up to three tokens per byte: pending end, own token, end-of-source flush
    typedef struct packed {
        logic   v0;
        logic   v1;
        logic   v2;
        t_token t0;
        t_token t1;
        t_token t2;
    } t_step;

    // entry: {length, byte0, byte1, byte2}
    localparam logic [25:0] SYM_TAB [SYM_COUNT] = '{
        {2'd3, "=", "=", "="}, {2'd3, "!", "=", "="}, {2'd3, "<", "<", "="},
        {2'd3, ">", ">", "="}, {2'd3, ">", ">", ">"}, {2'd2, "=", "=", 8'h00},
        {2'd2, "!", "=", 8'h00}, {2'd2, "&", "&", 8'h00}, {2'd2, "|", "|", 8'h00},
        {2'd2, ">", "=", 8'h00}, {2'd2, "<", "=", 8'h00}, {2'd2, "+", "=", 8'h00},
        {2'd2, "-", "=", 8'h00}, {2'd2, "*", "=", 8'h00}, {2'd2, "/", "=", 8'h00},
        {2'd2, "%", "=", 8'h00}, {2'd2, "&", "=", 8'h00}, {2'd2, "|", "=", 8'h00},
        {2'd2, "^", "=", 8'h00}, {2'd2, "+", "+", 8'h00}, {2'd2, "-", "-", 8'h00},
        {2'd2, ">", ">", 8'h00}, {2'd2, "<", "<", 8'h00}, {2'd2, "=", ">", 8'h00},
        {2'd1, "+", 16'h0000}, {2'd1, "-", 16'h0000}, {2'd1, "*", 16'h0000},
        {2'd1, "/", 16'h0000}, {2'd1, "%", 16'h0000}, {2'd1, "&", 16'h0000},
        {2'd1, "|", 16'h0000}, {2'd1, "^", 16'h0000}, {2'd1, "!", 16'h0000},
        {2'd1, "(", 16'h0000}, {2'd1, ")", 16'h0000}, {2'd1, "[", 16'h0000},
        {2'd1, "]", 16'h0000}, {2'd1, "{", 16'h0000}, {2'd1, "}", 16'h0000},
        {2'd1, ",", 16'h0000}, {2'd1, "?", 16'h0000}, {2'd1, ";", 16'h0000},
        {2'd1, ":", 16'h0000}, {2'd1, ".", 16'h0000}, {2'd1, ">", 16'h0000},
        {2'd1, "<", 16'h0000}, {2'd1, "@", 16'h0000}, {2'd1, "=", 16'h0000}
    };

    function automatic logic sym_prefix(input logic [25:0] e, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [1:0] len);
        return (e[23:16] == b0) && (len < 2'd2 || e[15:8] == b1)
               && (len < 2'd3 || e[7:0] == b2);
    endfunction

    // {hit, index}; lowest index wins
    function automatic logic [SYM_BITS:0] sym_find(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [1:0] len);
        logic [SYM_BITS:0] r;
        r = '0;
        for (int i = SYM_COUNT - 1; i >= 0; i--) begin
            if (SYM_TAB[i][25:24] == len && sym_prefix(SYM_TAB[i], b0, b1, b2, len)) begin
                r = {1'b1, SYM_BITS'(i)};
            end
        end
        return r;
    endfunction

    function automatic logic sym_extends(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [1:0] len);
        logic r;
        r = 1'b0;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (SYM_TAB[i][25:24] > len && sym_prefix(SYM_TAB[i], b0, b1, 8'h00, len)) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] sym_first(input logic [SYM_BITS-1:0] idx);
        return SYM_TAB[idx][23:16];
    endfunction

    function automatic logic sym_single(input logic [SYM_BITS-1:0] idx);
        return SYM_TAB[idx][25:24] == 2'd1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

endpackage

// ===== src/slbs_core.sv =====
`timescale 1ns / 1ps
module slbs_core import slbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_source,
    output t_step      o_step
);

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_look0, n_look0, r_look1, n_look1;
    logic [1:0]             r_look_cnt, n_look_cnt;
    logic [OFFSET_BITS-1:0] r_offset, n_offset, r_tstart, n_tstart, r_tlen, n_tlen;
    logic [LINE_BITS-1:0]   r_line, n_line, r_col, n_col, r_sline, n_sline, r_scol, n_scol;
    logic                   r_rx, n_rx;
    logic [BRACE_BITS-1:0]  r_brace, n_brace;
    logic [DEPTH_BITS-1:0]  r_tdepth, n_tdepth;
    logic [7:0]             r_qchar, n_qchar;
    logic                   r_esc, n_esc, r_aux, n_aux;

    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] abs_len;
    t_mode                  eff;
    logic                   again, do_sym, fin, cont;
    logic [7:0]             s_b0, s_b1;
    logic [1:0]             s_n;
    logic [SYM_BITS:0]      sf, fin_f, one_f;
    logic [OFFSET_BITS-1:0] fin_len;
    t_step                  st;

    assign c = i_char_byte;
    assign abs_len = (r_tlen != '1) ? r_tlen + 1'b1 : r_tlen;

    always_comb begin
        n_mode = r_mode; n_look0 = r_look0; n_look1 = r_look1; n_look_cnt = r_look_cnt;
        n_offset = r_offset; n_tstart = r_tstart; n_tlen = r_tlen;
        n_line = r_line; n_col = r_col; n_sline = r_sline; n_scol = r_scol;
        n_rx = r_rx; n_brace = r_brace; n_tdepth = r_tdepth;
        n_qchar = r_qchar; n_esc = r_esc; n_aux = r_aux;
        st = '0;
        st.t0.start = r_tstart; st.t0.line = r_sline; st.t0.col = r_scol; st.t0.len = r_tlen;
        st.t1.start = r_offset; st.t1.line = r_line; st.t1.col = r_col;
        st.t1.len = OFFSET_BITS'(1);
        again = 1'b0; do_sym = 1'b0; fin = 1'b0; cont = 1'b0;
        fin_f = '0; fin_len = r_tlen; sf = '0; one_f = '0;
        s_b0 = r_look0; s_b1 = r_look1;
        s_n = (r_look_cnt == 2'd2) ? 2'd2 : 2'd1;

        // phase one: the pending token sees the byte
        eff = r_mode;
        if (r_mode == M_ZERO && c != "x" && c != "o" && c != "b") begin
            eff = M_INT;
        end
        case (eff)
            M_IDLE: ;
            M_WORD: begin
                if (is_alpha(c) || is_digit(c)) n_tlen = abs_len;
                else begin
                    n_rx = 1'b0; st.v0 = 1'b1; st.t0.kind = K_WORD;
                    n_mode = M_IDLE; again = 1'b1;
                end
            end
            M_ZERO: begin
                n_tlen = abs_len;
                priority if (c == "x") n_mode = M_HEX;
                else if (c == "o") n_mode = M_OCT;
                else n_mode = M_BIN;
            end
            M_INT, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN: begin
                priority if ((eff == M_INT || eff == M_FRAC || eff == M_EXPD)
                             && is_digit(c)) begin
                    n_tlen = abs_len; n_mode = eff;
                end else if (eff == M_INT && c == ".") begin
                    n_tlen = abs_len; n_mode = M_FRAC;
                end else if ((eff == M_INT || eff == M_FRAC) && (c == "e" || c == "E")) begin
                    n_tlen = abs_len; n_mode = M_EXPS;
                end else if (eff == M_EXPS && (c == "+" || c == "-" || is_digit(c))) begin
                    n_tlen = abs_len; n_mode = M_EXPD;
                end else if ((eff == M_HEX && is_hex(c))
                             || (eff == M_OCT && c >= "0" && c <= "7")
                             || (eff == M_BIN && (c == "0" || c == "1"))) begin
                    n_tlen = abs_len;
                end else begin
                    n_rx = 1'b0; st.v0 = 1'b1; st.t0.kind = K_NUM;
                    n_mode = M_IDLE; again = 1'b1;
                end
            end
            M_LCOM: begin
                if (c == CH_LF) begin
                    st.v0 = 1'b1; st.t0.kind = K_COM; n_mode = M_IDLE; again = 1'b1;
                end else n_tlen = abs_len;
            end
            M_BCOM: begin
                n_tlen = abs_len;
                if (r_aux && c == "/") begin
                    st.v0 = 1'b1; st.t0.kind = K_COM; st.t0.len = abs_len; n_mode = M_IDLE;
                end else begin
                    n_qchar = 8'h00; n_esc = 1'b0; n_aux = (c == "*");
                end
            end
            M_SLASH: begin
                priority if (c == "/") begin
                    n_tlen = abs_len; n_mode = M_LCOM;
                end else if (c == "*") begin
                    n_tlen = abs_len; n_mode = M_BCOM;
                    n_qchar = 8'h00; n_esc = 1'b0; n_aux = 1'b0;
                end else if (r_rx) begin
                    n_tlen = abs_len; n_mode = M_RXB;
                    n_qchar = 8'h00; n_aux = 1'b0; n_esc = (c == CH_BSL);
                    if (c == "/") n_mode = M_RXF;
                end else begin
                    do_sym = 1'b1; s_b0 = "/"; s_n = 2'd1;
                end
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    n_tlen = abs_len; n_mode = M_FRAC;
                end else begin
                    do_sym = 1'b1; s_b0 = "."; s_n = 2'd1;
                end
            end
            M_SYM: do_sym = 1'b1;
            M_RXB: begin
                n_tlen = abs_len;
                priority if (r_esc) n_esc = 1'b0;
                else if (c == CH_BSL) n_esc = 1'b1;
                else if (c == "/") n_mode = M_RXF;
                else ;
            end
            M_RXF: begin
                if (c == "i" || c == "m" || c == "g") n_tlen = abs_len;
                else begin
                    n_rx = 1'b0; st.v0 = 1'b1; st.t0.kind = K_RX;
                    n_mode = M_IDLE; again = 1'b1;
                end
            end
            M_STR: begin
                n_tlen = abs_len;
                priority if (r_esc) n_esc = 1'b0;
                else if (c == CH_BSL) n_esc = 1'b1;
                else if (c == r_qchar) begin
                    n_rx = 1'b0; st.v0 = 1'b1; st.t0.kind = K_STR; st.t0.len = abs_len;
                    n_mode = M_IDLE;
                end else ;
            end
            M_TPL: begin
                cont = (r_qchar == "}");
                n_tlen = abs_len;
                priority if (r_esc) begin
                    n_esc = 1'b0; n_aux = 1'b0;
                end else if (c == CH_BSL) begin
                    n_aux = 1'b0; n_esc = 1'b1;
                end else if (c == CH_BTICK) begin
                    if (cont && r_tdepth != '0) n_tdepth = r_tdepth - 1'b1;
                    n_rx = 1'b0; st.v0 = 1'b1; st.t0.len = abs_len;
                    st.t0.kind = cont ? K_TEND : K_TPL; n_mode = M_IDLE;
                end else if (c == "{" && r_aux) begin
                    if (!cont && r_tdepth < DEPTH_BITS'(MAX_TEMPLATE_DEPTH)) begin
                        n_tdepth = r_tdepth + 1'b1;
                    end
                    n_rx = 1'b1; st.v0 = 1'b1; st.t0.len = abs_len;
                    st.t0.kind = cont ? K_TPART : K_TSTART; n_mode = M_IDLE;
                end else if (c == "$") n_aux = 1'b1;
                else n_aux = 1'b0;
            end
            default: begin
                n_mode = M_IDLE; again = 1'b1;
            end
        endcase

        // symbol lookahead: grow the match or close on the longest one
        if (do_sym) begin
            sf = sym_find(s_b0, (s_n == 2'd1) ? c : s_b1, (s_n == 2'd2) ? c : 8'h00,
                          s_n + 2'd1);
            if (sf[SYM_BITS]) begin
                n_tlen = abs_len;
                if (s_n == 2'd1 && sym_extends(s_b0, c, 2'd2)) begin
                    n_look0 = s_b0; n_look1 = c; n_look_cnt = 2'd2; n_mode = M_SYM;
                end else begin
                    fin = 1'b1; fin_f = sf; fin_len = abs_len;
                end
            end else begin
                fin = 1'b1; fin_f = sym_find(s_b0, s_b1, 8'h00, s_n); fin_len = r_tlen;
                again = 1'b1;
            end
        end
        if (fin) begin
            st.v0 = 1'b1; st.t0.len = fin_len; n_mode = M_IDLE;
            if (!fin_f[SYM_BITS]) st.t0.kind = K_ERR;
            else begin
                st.t0.kind = K_SYM; st.t0.sym = fin_f[SYM_BITS-1:0];
                if (sym_single(fin_f[SYM_BITS-1:0])) begin
                    if (sym_first(fin_f[SYM_BITS-1:0]) == "{" && n_brace != '1) begin
                        n_brace = n_brace + 1'b1;
                    end
                    if (sym_first(fin_f[SYM_BITS-1:0]) == "}" && n_brace != '0) begin
                        n_brace = n_brace - 1'b1;
                    end
                end
                n_rx = !(sym_single(fin_f[SYM_BITS-1:0])
                         && (sym_first(fin_f[SYM_BITS-1:0]) == ")"
                             || sym_first(fin_f[SYM_BITS-1:0]) == "]"
                             || sym_first(fin_f[SYM_BITS-1:0]) == "}"));
                n_look0 = 8'h00; n_look1 = 8'h00; n_look_cnt = 2'd0;
            end
        end

        // phase two: the byte opens a token of its own
        if ((r_mode == M_IDLE || again) && c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
            n_tstart = r_offset; n_sline = r_line; n_scol = r_col;
            n_tlen = OFFSET_BITS'(1);
            n_qchar = 8'h00; n_esc = 1'b0; n_aux = 1'b0;
            one_f = sym_find(c, 8'h00, 8'h00, 2'd1);
            priority if (c == CH_LF) begin
                st.v1 = 1'b1; st.t1.kind = K_EOL;
            end else if (c == "/") n_mode = M_SLASH;
            else if (c == CH_SQ || c == CH_DQ) begin
                n_mode = M_STR; n_qchar = c;
            end else if (c == CH_BTICK) begin
                n_mode = M_TPL; n_qchar = c;
            end else if (c == "}" && n_tdepth != '0 && n_brace == '0) begin
                n_mode = M_TPL; n_qchar = c;
            end else if (is_alpha(c)) n_mode = M_WORD;
            else if (c == "0") n_mode = M_ZERO;
            else if (is_digit(c)) n_mode = M_INT;
            else if (c == ".") n_mode = M_DOT;
            else if (!one_f[SYM_BITS]) begin
                st.v1 = 1'b1; st.t1.kind = K_ERR; n_mode = M_IDLE;
            end else if (sym_extends(c, 8'h00, 2'd1)) begin
                n_mode = M_SYM; n_look0 = c; n_look1 = 8'h00; n_look_cnt = 2'd1;
            end else begin
                st.v1 = 1'b1; st.t1.kind = K_SYM; st.t1.sym = one_f[SYM_BITS-1:0];
                if (c == "{" && n_brace != '1) n_brace = n_brace + 1'b1;
                if (c == "}" && n_brace != '0) n_brace = n_brace - 1'b1;
                n_rx = !(c == ")" || c == "]" || c == "}");
                n_mode = M_IDLE; n_look0 = 8'h00; n_look1 = 8'h00; n_look_cnt = 2'd0;
            end
        end

        // end of source: flush whatever is still open
        st.t2.start = n_tstart; st.t2.len = n_tlen; st.t2.line = n_sline; st.t2.col = n_scol;
        if (i_end_of_source) begin
            case (n_mode)
                M_WORD: begin st.v2 = 1'b1; st.t2.kind = K_WORD; end
                M_ZERO, M_INT, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN: begin
                    st.v2 = 1'b1; st.t2.kind = K_NUM;
                end
                M_LCOM: begin st.v2 = 1'b1; st.t2.kind = K_COM; end
                M_RXF:  begin st.v2 = 1'b1; st.t2.kind = K_RX; end
                M_SLASH: begin st.v2 = 1'b1; st.t2.kind = K_SYM; st.t2.sym = SYM_SLASH; end
                M_DOT:   begin st.v2 = 1'b1; st.t2.kind = K_SYM; st.t2.sym = SYM_DOT; end
                M_SYM: begin
                    sf = sym_find(n_look0, n_look1, 8'h00,
                                  (n_look_cnt == 2'd2) ? 2'd2 : 2'd1);
                    st.v2 = 1'b1;
                    st.t2.kind = sf[SYM_BITS] ? K_SYM : K_ERR;
                    st.t2.sym = sf[SYM_BITS] ? sf[SYM_BITS-1:0] : '0;
                end
                M_BCOM, M_STR, M_TPL, M_RXB: begin st.v2 = 1'b1; st.t2.kind = K_ERR; end
                default: ;
            endcase
        end

        // position advance
        if (r_offset != '1) n_offset = r_offset + 1'b1;
        if (c == CH_LF) begin
            if (r_line != '1) n_line = r_line + 1'b1;
            n_col = LINE_BITS'(1);
        end else if (c != CH_CR) begin
            if (r_col != '1) n_col = r_col + 1'b1;
        end
    end

    assign o_step = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end_of_source)) begin
            r_mode <= M_IDLE; r_look0 <= 8'h00; r_look1 <= 8'h00; r_look_cnt <= 2'd0;
            r_offset <= '0; r_tstart <= '0; r_tlen <= '0;
            r_line <= LINE_BITS'(1); r_col <= LINE_BITS'(1);
            r_sline <= LINE_BITS'(1); r_scol <= LINE_BITS'(1);
            r_rx <= 1'b1; r_brace <= '0; r_tdepth <= '0;
            r_qchar <= 8'h00; r_esc <= 1'b0; r_aux <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode; r_look0 <= n_look0; r_look1 <= n_look1; r_look_cnt <= n_look_cnt;
            r_offset <= n_offset; r_tstart <= n_tstart; r_tlen <= n_tlen;
            r_line <= n_line; r_col <= n_col; r_sline <= n_sline; r_scol <= n_scol;
            r_rx <= n_rx; r_brace <= n_brace; r_tdepth <= n_tdepth;
            r_qchar <= n_qchar; r_esc <= n_esc; r_aux <= n_aux;
        end
    end

endmodule

// ===== src/script_lexer_byte_stream_unit.sv =====
`timescale 1ns / 1ps
// Streaming script lexer. Source bytes enter one per request on the input
// channel; tokens leave one per request on the output channel with kind,
// symbol index, start offset, length, line and column of the token start.
// A byte is taken every cycle as long as at most one token waits in the
// four-entry result queue; the byte's whole lexer update happens in the
// cycle it is taken. One byte can close a pending token, make a one-byte
// token of its own and, with end_of_source, flush what is still open: up to
// three tokens, which drain at one per cycle while the output is not
// stalled, so input is held off while two or more tokens are queued.
// last_of_run marks the final token a byte produced. After an end_of_source
// byte the lexer starts over at offset 0, line 1, column 1.
module script_lexer_byte_stream_unit import slbs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_char_byte,
    input  logic                   i_end_of_source,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_token_kind,
    output logic [SYM_BITS-1:0]    o_symbol_index,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [OFFSET_BITS-1:0] o_token_length,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [LINE_BITS-1:0]   o_column_number,
    output logic                   o_last_of_run
);

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_qent;

    logic       in_acc, pop;
    t_step      step;
    t_qent      r_mem [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_count, n_count;
    t_qent      lst [3];
    logic [1:0] push_n;

    // take a new byte only while the queue can absorb a worst-case burst
    assign o_in_stall = (r_count >= 3'd2);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pop        = (r_count != 3'd0) && !i_out_stall;

    slbs_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (in_acc),
        .i_char_byte     (i_char_byte),
        .i_end_of_source (i_end_of_source),
        .o_step          (step)
    );

    // pack the produced tokens in order and flag the final one
    always_comb begin
        lst[0] = '0; lst[1] = '0; lst[2] = '0;
        push_n = 2'd0;
        if (step.v0) begin lst[push_n].tok = step.t0; push_n = push_n + 2'd1; end
        if (step.v1) begin lst[push_n].tok = step.t1; push_n = push_n + 2'd1; end
        if (step.v2) begin lst[push_n].tok = step.t2; push_n = push_n + 2'd1; end
        if (push_n != 2'd0) lst[push_n - 2'd1].last = 1'b1;
        if (!in_acc) push_n = 2'd0;
    end

    assign n_count = r_count + 3'(push_n) - 3'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 2'd0; r_wr <= 2'd0; r_count <= 3'd0;
        end else begin
            if (pop) r_rd <= r_rd + 2'd1;
            r_wr    <= r_wr + push_n;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_n) r_mem[r_wr + 2'(k)] <= lst[k];
        end
    end

    assign o_out_valid     = (r_count != 3'd0);
    assign o_token_kind    = r_mem[r_rd].tok.kind;
    assign o_symbol_index  = r_mem[r_rd].tok.sym;
    assign o_start_offset  = r_mem[r_rd].tok.start;
    assign o_token_length  = r_mem[r_rd].tok.len;
    assign o_line_number   = r_mem[r_rd].tok.line;
    assign o_column_number = r_mem[r_rd].tok.col;
    assign o_last_of_run   = r_mem[r_rd].last;

endmodule

// ===== src/slbs_checker.sv =====
`timescale 1ns / 1ps
module slbs_checker import slbs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic [7:0]             i_char_byte,
    input logic                   i_end_of_source,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [3:0]             o_token_kind,
    input logic [SYM_BITS-1:0]    o_symbol_index,
    input logic [OFFSET_BITS-1:0] o_start_offset,
    input logic [OFFSET_BITS-1:0] o_token_length,
    input logic [LINE_BITS-1:0]   o_line_number,
    input logic [LINE_BITS-1:0]   o_column_number,
    input logic                   o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_start_offset) && $stable(o_last_of_run))
        else $error("stalled token changed");

    a_sym_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != K_SYM |-> o_symbol_index == '0)
        else $error("symbol index on non-symbol token");

    a_eol_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_EOL |-> o_token_length == OFFSET_BITS'(1))
        else $error("end-of-line token length");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_number != '0 && o_column_number != '0)
        else $error("zero line or column");

endmodule

bind script_lexer_byte_stream_unit slbs_checker u_slbs_checker (.*);
